// File: hw/rtl/peer_wire_message_deframer_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; included by files that carry assertions
`ifndef PEER_WIRE_MESSAGE_DEFRAMER_MACROS_SVH
`define PEER_WIRE_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define PWMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pwmd_pkg.sv
// types and constants for the peer wire message deframer
// no dependencies; imported by pwmd_core and peer_wire_message_deframer
package pwmd_pkg;

  localparam int unsigned POS_W = 21;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_HASH         = 4'd0;
  localparam kind_t KIND_PEER_ID      = 4'd1;
  localparam kind_t KIND_HS_DONE      = 4'd2;
  localparam kind_t KIND_KEEPALIVE    = 4'd3;
  localparam kind_t KIND_CHOKE        = 4'd4;
  localparam kind_t KIND_HAVE         = 4'd8;
  localparam kind_t KIND_BITFIELD     = 4'd9;
  localparam kind_t KIND_REQUEST      = 4'd10;
  localparam kind_t KIND_PIECE_HDR    = 4'd11;
  localparam kind_t KIND_PIECE_BYTE   = 4'd12;
  localparam kind_t KIND_CANCEL       = 4'd13;
  localparam kind_t KIND_UNKNOWN      = 4'd14;
  localparam kind_t KIND_ERROR        = 4'd15;

  localparam logic [7:0] MSG_LAST_STATE = 8'd3;
  localparam logic [7:0] MSG_HAVE       = 8'd4;
  localparam logic [7:0] MSG_BITFIELD   = 8'd5;
  localparam logic [7:0] MSG_REQUEST    = 8'd6;
  localparam logic [7:0] MSG_PIECE      = 8'd7;
  localparam logic [7:0] MSG_CANCEL     = 8'd8;

  localparam logic [POS_W-1:0] HAVE_MIN_LEN    = 21'd5;
  localparam logic [POS_W-1:0] PIECE_MIN_LEN   = 21'd9;
  localparam logic [POS_W-1:0] REQUEST_MIN_LEN = 21'd13;

  localparam logic [POS_W-1:0] HS_FIELD_BYTES  = 21'd20;
  localparam logic [POS_W-1:0] FLAG_BYTES      = 21'd8;
  localparam logic [POS_W-1:0] PIECE_HDR_BYTES = 21'd8;
  localparam logic [POS_W-1:0] PREFIX_BYTES    = 21'd4;
  localparam logic [POS_W-1:0] INDEX_END       = 21'd3;
  localparam logic [POS_W-1:0] OFFSET_END      = 21'd7;
  localparam logic [POS_W-1:0] LENGTH_END      = 21'd11;

  localparam logic [7:0] PRINT_MIN  = 8'd32;
  localparam logic [7:0] PRINT_MAX  = 8'd126;
  localparam logic [7:0] SUBST_CHAR = 8'h2E;

  localparam logic [POS_W-1:0] MAX_LEN_RESET = 21'd16393;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [31:0]      piece_index;
    logic [31:0]      block_offset;
    logic [31:0]      block_length;
    logic [7:0]       payload_byte;
    logic [POS_W-1:0] byte_position;
    logic             last;
  } pwmd_result_t;

endpackage

// File: hw/rtl/peer_wire_message_deframer.sv
// peer wire message deframer: one byte register, parser core, result register
// an accepted byte goes from the byte register through the parser core into the result register
// throughput: one byte per cycle while the result side does not stall, set by the single parser pass per byte
// stalls on the result side hold the byte register and push back on input
// reset is synchronous: parser returns to name length phase, register to 16393
// depends on pwmd_pkg, pwmd_core and peer_wire_message_deframer_macros.svh
`include "peer_wire_message_deframer_macros.svh"

module peer_wire_message_deframer import pwmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_enable,
  input  logic [20:0]      cfg_write_data,
  input  logic             data_valid,
  output logic             data_stall,
  input  logic [7:0]       data_byte,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [3:0]       kind,
  output logic [31:0]      piece_index,
  output logic [31:0]      block_offset,
  output logic [31:0]      block_length,
  output logic [7:0]       payload_byte,
  output logic [20:0]      byte_position,
  output logic             last
);

  logic [POS_W-1:0] max_message_length;
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             out_free;
  logic             advance;
  pwmd_result_t     core_result;

  assign out_free   = !result_valid || !result_stall;
  assign data_stall = hold_valid && !out_free;
  assign advance    = hold_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= MAX_LEN_RESET;
    end else if (cfg_write_enable) begin
      max_message_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      hold_byte <= data_byte;
    end
  end

  pwmd_core u_core (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .data_byte          (hold_byte),
    .max_message_length (max_message_length),
    .result             (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && core_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && core_result.valid) begin
      kind          <= core_result.kind;
      piece_index   <= core_result.piece_index;
      block_offset  <= core_result.block_offset;
      block_length  <= core_result.block_length;
      payload_byte  <= core_result.payload_byte;
      byte_position <= core_result.byte_position;
      last          <= core_result.last;
    end
  end

  `PWMD_ASSERT_NEXT(a_hold_kept, clk, rst, hold_valid && !out_free,
                    hold_valid && $stable(hold_byte), "held byte lost under stall")
  `PWMD_ASSERT_NEXT(a_accept_holds, clk, rst, data_valid && !data_stall,
                    hold_valid, "accepted transaction not held")
  `PWMD_ASSERT_NOW(a_last_kinds, clk, rst, result_valid && last,
                   kind == KIND_HASH || kind == KIND_HS_DONE || kind == KIND_BITFIELD ||
                   kind == KIND_PIECE_BYTE, "last flag on non-byte kind")

endmodule

// File: hw/rtl/pwmd_core.sv
// parser state and per-byte next-state and result logic
// depends on pwmd_pkg and peer_wire_message_deframer_macros.svh
`include "peer_wire_message_deframer_macros.svh"

module pwmd_core import pwmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  logic [POS_W-1:0] max_message_length,
  output pwmd_result_t     result
);

  typedef enum logic [3:0] {
    PH_NAME_LEN, PH_NAME, PH_FLAGS, PH_HASH, PH_PEER_ID, PH_LENGTH,
    PH_ID, PH_FIELDS, PH_PAYLOAD, PH_SKIP, PH_HALT
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_count, byte_count_next;
  logic [7:0]       name_length, name_length_next;
  logic [POS_W-1:0] message_length, message_length_next;
  logic [7:0]       message_id, message_id_next;
  logic [31:0]      field_acc, field_acc_next;
  logic [31:0]      held_index, held_index_next;
  logic [31:0]      held_offset, held_offset_next;

  logic [POS_W-1:0] k_inc;
  logic             msg_done;
  logic             hs_done;
  logic [31:0]      acc_shift;
  logic [7:0]       sanitized;
  logic             rem_nz;

  assign k_inc     = byte_count + 21'd1;
  assign msg_done  = ({1'b0, byte_count} + 22'd2) >= {1'b0, message_length};
  assign hs_done   = k_inc >= HS_FIELD_BYTES;
  assign acc_shift = {field_acc[23:0], data_byte};
  assign sanitized = (data_byte < PRINT_MIN || data_byte > PRINT_MAX) ? SUBST_CHAR : data_byte;
  assign rem_nz    = message_length != 21'd1;

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    name_length_next    = name_length;
    message_length_next = message_length;
    message_id_next     = message_id;
    field_acc_next      = field_acc;
    held_index_next     = held_index;
    held_offset_next    = held_offset;
    result              = '0;

    case (phase)
      PH_NAME_LEN: begin
        name_length_next = data_byte;
        byte_count_next  = '0;
        phase_next       = (data_byte != 8'd0) ? PH_NAME : PH_FLAGS;
      end
      PH_NAME: begin
        if (k_inc >= {13'd0, name_length}) begin
          byte_count_next = '0;
          phase_next      = PH_FLAGS;
        end else begin
          byte_count_next = k_inc;
        end
      end
      PH_FLAGS: begin
        if (k_inc >= FLAG_BYTES) begin
          byte_count_next = '0;
          phase_next      = PH_HASH;
        end else begin
          byte_count_next = k_inc;
        end
      end
      PH_HASH: begin
        result.valid         = 1'b1;
        result.kind          = KIND_HASH;
        result.payload_byte  = data_byte;
        result.byte_position = byte_count;
        result.last          = hs_done;
        byte_count_next      = hs_done ? '0 : k_inc;
        if (hs_done) begin
          phase_next = PH_PEER_ID;
        end
      end
      PH_PEER_ID: begin
        result.valid         = 1'b1;
        result.kind          = hs_done ? KIND_HS_DONE : KIND_PEER_ID;
        result.payload_byte  = sanitized;
        result.byte_position = byte_count;
        result.last          = hs_done;
        if (hs_done) begin
          phase_next      = PH_LENGTH;
          byte_count_next = '0;
          field_acc_next  = '0;
        end else begin
          byte_count_next = k_inc;
        end
      end
      PH_LENGTH: begin
        field_acc_next  = acc_shift;
        byte_count_next = k_inc;
        if (k_inc >= PREFIX_BYTES) begin
          byte_count_next = '0;
          field_acc_next  = '0;
          if (acc_shift == 32'd0) begin
            result.valid = 1'b1;
            result.kind  = KIND_KEEPALIVE;
          end else if (acc_shift > {11'd0, max_message_length}) begin
            result.valid        = 1'b1;
            result.kind         = KIND_ERROR;
            result.block_length = acc_shift;
            phase_next          = PH_HALT;
          end else begin
            message_length_next = acc_shift[POS_W-1:0];
            phase_next          = PH_ID;
          end
        end
      end
      PH_ID: begin
        message_id_next = data_byte;
        byte_count_next = '0;
        field_acc_next  = '0;
        if (data_byte <= MSG_LAST_STATE) begin
          result.valid = 1'b1;
          result.kind  = KIND_CHOKE + {2'd0, data_byte[1:0]};
          phase_next   = rem_nz ? PH_SKIP : PH_LENGTH;
        end else if (data_byte == MSG_HAVE) begin
          if (message_length < HAVE_MIN_LEN) begin
            result.valid        = 1'b1;
            result.kind         = KIND_ERROR;
            result.block_length = {11'd0, message_length};
            phase_next          = PH_HALT;
          end else begin
            phase_next = PH_FIELDS;
          end
        end else if (data_byte == MSG_BITFIELD) begin
          phase_next = rem_nz ? PH_PAYLOAD : PH_LENGTH;
        end else if (data_byte == MSG_REQUEST || data_byte == MSG_CANCEL) begin
          if (message_length < REQUEST_MIN_LEN) begin
            result.valid        = 1'b1;
            result.kind         = KIND_ERROR;
            result.block_length = {11'd0, message_length};
            phase_next          = PH_HALT;
          end else begin
            phase_next = PH_FIELDS;
          end
        end else if (data_byte == MSG_PIECE) begin
          if (message_length < PIECE_MIN_LEN) begin
            result.valid        = 1'b1;
            result.kind         = KIND_ERROR;
            result.block_length = {11'd0, message_length};
            phase_next          = PH_HALT;
          end else begin
            phase_next = PH_FIELDS;
          end
        end else begin
          result.valid        = 1'b1;
          result.kind         = KIND_UNKNOWN;
          result.payload_byte = data_byte;
          phase_next          = rem_nz ? PH_SKIP : PH_LENGTH;
        end
      end
      PH_FIELDS: begin
        field_acc_next  = acc_shift;
        byte_count_next = k_inc;
        if (byte_count == INDEX_END) begin
          held_index_next = acc_shift;
        end
        if (byte_count == OFFSET_END) begin
          held_offset_next = acc_shift;
        end
        if (message_id == MSG_HAVE && byte_count == INDEX_END) begin
          result.valid       = 1'b1;
          result.kind        = KIND_HAVE;
          result.piece_index = acc_shift;
          phase_next         = PH_SKIP;
        end else if (message_id == MSG_PIECE && byte_count == OFFSET_END) begin
          result.valid        = 1'b1;
          result.kind         = KIND_PIECE_HDR;
          result.piece_index  = held_index;
          result.block_offset = acc_shift;
          result.block_length = {11'd0, message_length} - 32'd9;
          phase_next          = PH_PAYLOAD;
        end else if ((message_id == MSG_REQUEST || message_id == MSG_CANCEL) &&
                     byte_count == LENGTH_END) begin
          result.valid        = 1'b1;
          result.kind         = (message_id == MSG_REQUEST) ? KIND_REQUEST : KIND_CANCEL;
          result.piece_index  = held_index;
          result.block_offset = held_offset;
          result.block_length = acc_shift;
          phase_next          = PH_SKIP;
        end
        if (msg_done) begin
          phase_next      = PH_LENGTH;
          byte_count_next = '0;
          field_acc_next  = '0;
        end
      end
      PH_PAYLOAD: begin
        result.valid        = 1'b1;
        result.kind         = (message_id == MSG_PIECE) ? KIND_PIECE_BYTE : KIND_BITFIELD;
        result.payload_byte = data_byte;
        result.byte_position = (message_id == MSG_PIECE) ?
                               byte_count - PIECE_HDR_BYTES : byte_count;
        result.last         = msg_done;
        if (msg_done) begin
          phase_next      = PH_LENGTH;
          byte_count_next = '0;
          field_acc_next  = '0;
        end else begin
          byte_count_next = k_inc;
        end
      end
      PH_SKIP: begin
        if (msg_done) begin
          phase_next      = PH_LENGTH;
          byte_count_next = '0;
          field_acc_next  = '0;
        end else begin
          byte_count_next = k_inc;
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NAME_LEN;
      byte_count     <= '0;
      name_length    <= '0;
      message_length <= '0;
      message_id     <= '0;
      field_acc      <= '0;
      held_index     <= '0;
      held_offset    <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      name_length    <= name_length_next;
      message_length <= message_length_next;
      message_id     <= message_id_next;
      field_acc      <= field_acc_next;
      held_index     <= held_index_next;
      held_offset    <= held_offset_next;
    end
  end

  `PWMD_ASSERT_NEXT(a_halt_sticks, clk, rst, phase == PH_HALT, phase == PH_HALT, "parser left halt")
  `PWMD_ASSERT_NOW(a_halt_silent, clk, rst, phase == PH_HALT, !result.valid, "result while halted")
  `PWMD_ASSERT_NEXT(a_error_halts, clk, rst, advance && result.valid && result.kind == KIND_ERROR,
                    phase == PH_HALT, "error without halt")

endmodule
